>>> rtl/fms_pkg.sv
// ----------------------------------------------------------------------------
// fms_pkg
// Shared types and constants of the k-mer sampler: window and queue sizes,
// configuration bundle, character codes, hash constants, hash engine states.
// ----------------------------------------------------------------------------
package fms_pkg;

  // Window limits
  localparam int unsigned MaxK          = 31;
  localparam int unsigned WinW          = 2 * MaxK;   // packed window bits
  localparam int unsigned KW            = 5;          // k-mer length field
  localparam int unsigned MaxShardBits  = 16;
  localparam int unsigned ShardW        = 16;
  localparam int unsigned HashW         = 64;

  // Queue between parser and hash engine
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  // Configuration port
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 64;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_KMER_LENGTH    = 3'd0,
    CFG_FASTQ_MODE     = 3'd1,
    CFG_MASK_SEL       = 3'd2,
    CFG_SAMPLE_MASK    = 3'd3,
    CFG_KEEP_THRESHOLD = 3'd4,
    CFG_SHARD_WIDTH    = 3'd5
  } cfg_idx_e;

  // Reset values of the registers
  localparam logic [KW-1:0] KmerLenRst    = 5'd21;
  localparam logic          FastqRst      = 1'b1;
  localparam logic          UseMaskRst    = 1'b1;
  localparam logic [31:0]   SampleMaskRst = 32'd1023;
  localparam logic [63:0]   ThresholdRst  = 64'd0;
  localparam logic [4:0]    ShardBitsRst  = 5'd8;
  localparam logic [4:0]    ShardBitsDflt = 5'd8;

  typedef struct packed {
    logic [KW-1:0] kmer_length;
    logic          fastq_mode;
    logic          mask_sel;
    logic [31:0]   sample_mask;
    logic [63:0]   keep_threshold;
    logic [4:0]    shard_width;
  } cfg_t;

  // Text characters
  localparam logic [7:0] ChNl = 8'h0A;
  localparam logic [7:0] ChCr = 8'h0D;
  localparam logic [7:0] ChGt = 8'h3E;

  // SplitMix64 constants
  localparam logic [63:0] MixAdd  = 64'h9e3779b97f4a7c15;
  localparam logic [63:0] MixMul1 = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] MixMul2 = 64'h94d049bb133111eb;

  // Hash engine: each 64-bit product is built from three 32x32 partials
  localparam logic [1:0] StepLast = 2'd2;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_MUL1,
    BK_MUL2,
    BK_FINAL
  } bk_state_e;

endpackage

>>> rtl/fms_if.sv
// ----------------------------------------------------------------------------
// fms_if
// Valid/ready channels of the sampler: text bytes in, kept hashes out.
// ----------------------------------------------------------------------------
interface fms_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       chunk_start;

  modport source (output valid, output text_byte, output chunk_start, input ready);
  modport sink   (input valid, input text_byte, input chunk_start, output ready);
endinterface

interface fms_hash_if;
  logic        valid;
  logic        ready;
  logic [63:0] kept_hash;
  logic [15:0] shard_index;

  modport source (output valid, output kept_hash, output shard_index, input ready);
  modport sink   (input valid, input kept_hash, input shard_index, output ready);
endinterface

>>> rtl/fracminhash_kmer_sampler_top.sv
// ----------------------------------------------------------------------------
// fracminhash_kmer_sampler_top
// Streaming FracMinHash sampler: FASTA/FASTQ text bytes in, sampled
// canonical k-mer hashes with shard index out.
//
// Usage:
//   byte_i carries one text word per handshake (text_byte, chunk_start).
//   The parser takes one word per cycle while its queue has room.
//   hash_o carries one word per kept hash (kept_hash, shard_index).
//   Every base that completes a k-mer passes through the hash engine: a
//   load, two 64-bit multiplies built from partial products on one 32x32
//   multiplier, and a sampling step; other words cost nothing there.
//   A 4-deep queue between parser and engine lets the parser keep taking
//   words while the engine works, so sustained rate is 1 word/cycle for
//   non-k-mer words while the queue has room, and the engine takes a new
//   k-mer only once it is done with the last one. When the receiver stalls,
//   the kept hash holds in the output register, the engine waits with the
//   next one, then the queue fills and byte_i.ready drops. Reset clears the
//   window, parser phase, queue and output, and loads register defaults. The
//   user must write configuration through cfg_we_i/cfg_index_i/cfg_data_i
//   only while the block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module fracminhash_kmer_sampler_top
  import fms_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  fms_byte_if.sink            byte_i,
  fms_hash_if.source          hash_o
);

  cfg_t            cfg_q;
  logic            q_full;
  logic            q_push;
  logic [WinW-1:0] q_push_data;
  logic            q_valid;
  logic [WinW-1:0] q_data;
  logic            q_pop;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.kmer_length    <= KmerLenRst;
      cfg_q.fastq_mode     <= FastqRst;
      cfg_q.mask_sel       <= UseMaskRst;
      cfg_q.sample_mask    <= SampleMaskRst;
      cfg_q.keep_threshold <= ThresholdRst;
      cfg_q.shard_width    <= ShardBitsRst;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_KMER_LENGTH:    cfg_q.kmer_length    <= cfg_data_i[KW-1:0];
        CFG_FASTQ_MODE:     cfg_q.fastq_mode     <= cfg_data_i[0];
        CFG_MASK_SEL:       cfg_q.mask_sel       <= cfg_data_i[0];
        CFG_SAMPLE_MASK:    cfg_q.sample_mask    <= cfg_data_i[31:0];
        CFG_KEEP_THRESHOLD: cfg_q.keep_threshold <= cfg_data_i;
        CFG_SHARD_WIDTH:    cfg_q.shard_width    <= cfg_data_i[4:0];
        default:            cfg_q                <= cfg_q;
      endcase
    end
  end

  fms_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .byte_i   (byte_i),
    .q_full_i (q_full),
    .q_push_o (q_push),
    .q_data_o (q_push_data)
  );

  fms_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_push_data),
    .full_o      (q_full),
    .valid_o     (q_valid),
    .data_o      (q_data),
    .pop_i       (q_pop)
  );

  fms_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .q_valid_i (q_valid),
    .q_data_i  (q_data),
    .q_pop_o   (q_pop),
    .hash_o    (hash_o)
  );

endmodule

>>> rtl/fms_front.sv
// ----------------------------------------------------------------------------
// fms_front
// Record parser and rolling window. Takes one word per cycle while the queue
// has room, follows FASTA/FASTQ line structure, queues each full canonical k-mer.
// ----------------------------------------------------------------------------
module fms_front
  import fms_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  cfg_t            cfg_i,
  fms_byte_if.sink        byte_i,
  input  logic            q_full_i,
  output logic            q_push_o,
  output logic [WinW-1:0] q_data_o
);

  logic [WinW-1:0] fwd_q, fwd_d;
  logic [WinW-1:0] rev_q, rev_d;
  logic [KW-1:0]   fill_q, fill_d;
  logic [1:0]      phase_q, phase_d;
  logic            inseq_q, inseq_d;
  logic            accept;
  logic            push;

  assign byte_i.ready = ~q_full_i;
  assign accept       = byte_i.valid & ~q_full_i;

  // Parse one word and roll the window
  always_comb begin
    logic [7:0]      ch;
    logic            is_base;
    logic            valid_base;
    logic [1:0]      code;
    logic [KW-1:0]   k;
    logic [63:0]     wmask;
    logic [5:0]      top_sh;
    logic [WinW-1:0] rev_new;

    ch      = byte_i.text_byte;
    fwd_d   = fwd_q;
    rev_d   = rev_q;
    fill_d  = fill_q;
    phase_d = phase_q;
    inseq_d = inseq_q;
    is_base = 1'b0;
    push    = 1'b0;

    if (byte_i.chunk_start) begin
      fwd_d   = '0;
      rev_d   = '0;
      fill_d  = '0;
      phase_d = 2'd0;
      inseq_d = 1'b0;
    end

    if (cfg_i.fastq_mode) begin
      if (ch == ChNl) begin
        if (phase_d == 2'd0) begin
          inseq_d = 1'b1;
          fwd_d   = '0;
          rev_d   = '0;
          fill_d  = '0;
        end else begin
          inseq_d = 1'b0;
        end
        phase_d = phase_d + 2'd1;
      end else if (phase_d == 2'd1 && ch != ChCr) begin
        is_base = 1'b1;
      end
    end else begin
      if (ch == ChGt) begin
        inseq_d = 1'b0;
        fwd_d   = '0;
        rev_d   = '0;
        fill_d  = '0;
      end else if (ch == ChNl) begin
        inseq_d = 1'b1;
      end else if (inseq_d && ch != ChCr) begin
        is_base = 1'b1;
      end
    end

    // Base decode, either case
    valid_base = 1'b1;
    case (ch)
      8'h41, 8'h61: code = 2'd0;
      8'h43, 8'h63: code = 2'd1;
      8'h47, 8'h67: code = 2'd2;
      8'h54, 8'h74: code = 2'd3;
      default: begin
        code       = 2'd0;
        valid_base = 1'b0;
      end
    endcase

    k       = (cfg_i.kmer_length == '0) ? KW'(1) : cfg_i.kmer_length;
    wmask   = (64'd1 << {k, 1'b0}) - 64'd1;
    top_sh  = {k - KW'(1), 1'b0};
    rev_new = (rev_d >> 2) | (WinW'(~code) << top_sh);

    if (is_base) begin
      if (!valid_base) begin
        fwd_d  = '0;
        rev_d  = '0;
        fill_d = '0;
      end else begin
        fwd_d  = {fwd_d[WinW-3:0], code} & wmask[WinW-1:0];
        rev_d  = rev_new & wmask[WinW-1:0];
        fill_d = (fill_d < k) ? fill_d + KW'(1) : k;
        push   = (fill_d == k);
      end
    end
  end

  assign q_push_o = accept & push;
  assign q_data_o = (fwd_d < rev_d) ? fwd_d : rev_d;

  // Parser and window state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q   <= '0;
      rev_q   <= '0;
      fill_q  <= '0;
      phase_q <= 2'd0;
      inseq_q <= 1'b0;
    end else if (accept) begin
      fwd_q   <= fwd_d;
      rev_q   <= rev_d;
      fill_q  <= fill_d;
      phase_q <= phase_d;
      inseq_q <= inseq_d;
    end
  end

endmodule

>>> rtl/fms_queue.sv
// ----------------------------------------------------------------------------
// fms_queue
// Short FIFO of canonical k-mers between the parser and the hash engine.
// ----------------------------------------------------------------------------
module fms_queue
  import fms_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  logic [WinW-1:0] push_data_i,
  output logic            full_o,
  output logic            valid_o,
  output logic [WinW-1:0] data_o,
  input  logic            pop_i
);

  logic [WinW-1:0]  mem_q [QDepth];
  logic [QPtrW-1:0] wr_q, rd_q;
  logic [QCntW-1:0] cnt_q;
  logic             do_pop;

  assign full_o  = (cnt_q == QCntW'(QDepth));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_q];
  assign do_pop  = pop_i & valid_o;

  // Storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + QPtrW'(1);
      if (do_pop) rd_q <= rd_q + QPtrW'(1);
      if (push_i && !do_pop) begin
        cnt_q <= cnt_q + QCntW'(1);
      end else if (!push_i && do_pop) begin
        cnt_q <= cnt_q - QCntW'(1);
      end
    end
  end

endmodule

>>> rtl/fms_back.sv
// ----------------------------------------------------------------------------
// fms_back
// Hash engine: SplitMix64 over a shared 32x32 multiplier (three partial
// products per 64-bit multiply), sampling test and output register.
// ----------------------------------------------------------------------------
module fms_back
  import fms_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  cfg_t            cfg_i,
  input  logic            q_valid_i,
  input  logic [WinW-1:0] q_data_i,
  output logic            q_pop_o,
  fms_hash_if.source      hash_o
);

  bk_state_e   state_q, state_d;
  logic [1:0]  step_q;
  logic [63:0] opnd_q;
  logic [63:0] acc_q, acc_d;
  logic        out_valid_q;
  logic [63:0] out_hash_q;
  logic [15:0] out_shard_q;

  logic [63:0] mul_const;
  logic [31:0] mul_a, mul_b;
  logic [63:0] prod;
  logic [63:0] seed;
  logic [63:0] hash;
  logic        keep;
  logic        out_free;
  logic [4:0]  sb;
  logic [15:0] shard;
  logic        load_out;
  logic        step_done;

  // Shared multiplier, partial product selected by step
  assign mul_const = (state_q == BK_MUL2) ? MixMul2 : MixMul1;
  assign mul_a     = (step_q == 2'd1) ? opnd_q[63:32] : opnd_q[31:0];
  assign mul_b     = (step_q == StepLast) ? mul_const[63:32] : mul_const[31:0];
  assign prod      = 64'(mul_a) * 64'(mul_b);
  assign acc_d     = (step_q == 2'd0) ? prod : acc_q + {prod[31:0], 32'd0};
  assign step_done = (step_q == StepLast);

  assign seed = 64'(q_data_i) + MixAdd;
  assign hash = acc_q ^ (acc_q >> 31);

  // Sampling test and shard index
  assign keep = cfg_i.mask_sel ? ((hash[31:0] & cfg_i.sample_mask) == 32'd0)
                               : (hash < cfg_i.keep_threshold);
  assign sb   = (cfg_i.shard_width == 5'd0) ? ShardBitsDflt :
                (cfg_i.shard_width > 5'(MaxShardBits)) ? 5'(MaxShardBits) :
                cfg_i.shard_width;
  assign shard    = hash[63:48] >> (5'(ShardW) - sb);
  assign out_free = ~out_valid_q | hash_o.ready;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_IDLE:  if (q_valid_i) state_d = BK_MUL1;
      BK_MUL1:  if (step_done) state_d = BK_MUL2;
      BK_MUL2:  if (step_done) state_d = BK_FINAL;
      BK_FINAL: if (!keep || out_free) state_d = BK_IDLE;
      default:  state_d = BK_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    q_pop_o  = 1'b0;
    load_out = 1'b0;
    case (state_q)
      BK_IDLE:  q_pop_o  = q_valid_i;
      BK_FINAL: load_out = keep & out_free;
      default: begin
        q_pop_o  = 1'b0;
        load_out = 1'b0;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      step_q      <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if ((state_q == BK_MUL1 || state_q == BK_MUL2) && !step_done) begin
        step_q <= step_q + 2'd1;
      end else begin
        step_q <= 2'd0;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (hash_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      BK_IDLE: begin
        if (q_valid_i) opnd_q <= seed ^ (seed >> 30);
      end
      BK_MUL1: begin
        acc_q <= acc_d;
        if (step_done) opnd_q <= acc_d ^ (acc_d >> 27);
      end
      BK_MUL2: acc_q <= acc_d;
      default: acc_q <= acc_q;
    endcase
    if (load_out) begin
      out_hash_q  <= hash;
      out_shard_q <= shard;
    end
  end

  assign hash_o.valid       = out_valid_q;
  assign hash_o.kept_hash   = out_hash_q;
  assign hash_o.shard_index = out_shard_q;

endmodule

>>> bench/fracminhash_kmer_sampler_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fracminhash_kmer_sampler_top_tb
// Self-checking bench for the k-mer sampler. FASTA and FASTQ records with
// random content, broken records and stray bytes are streamed into byte_i
// under several register settings. A predictor in the bench parses the same
// words and queues the hashes it expects to be kept; every word on hash_o is
// checked against the oldest one. Both sides stall at random, and once the
// receiver holds off long enough for the block to stall its input.
// ----------------------------------------------------------------------------
module fracminhash_kmer_sampler_top_tb;
  import fms_pkg::*;

  localparam int unsigned CycleLimit    = 200000;
  localparam int unsigned DrainCycles   = 64;
  localparam int unsigned IdlePct       = 27;
  localparam int unsigned HoldoffCycles = 300;

  // Indexes past the register list, written to check that they are ignored
  localparam logic [CfgIdxW-1:0] CfgIdxSpareLo = 3'd6;
  localparam logic [CfgIdxW-1:0] CfgIdxSpareHi = 3'd7;

  localparam logic [7:0] ChAt   = 8'h40;
  localparam logic [7:0] ChPlus = 8'h2B;

  // 2-bit base codes
  localparam logic [1:0] BaseA     = 2'd0;
  localparam logic [1:0] BaseC     = 2'd1;
  localparam logic [1:0] BaseG     = 2'd2;
  localparam logic [1:0] BaseT     = 2'd3;
  localparam logic [1:0] ComplMask = 2'b11;

  // FASTQ line phases
  localparam logic [1:0] LineHeader = 2'd0;
  localparam logic [1:0] LineSeq    = 2'd1;

  // SplitMix64 constants
  localparam logic [63:0] GoldenAdd = 64'h9e3779b97f4a7c15;
  localparam logic [63:0] MixMulA   = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] MixMulB   = 64'h94d049bb133111eb;

  typedef struct packed {
    logic [7:0] ch;
    logic       chunk;
  } text_word_t;

  typedef struct packed {
    logic [63:0] hash;
    logic [15:0] shard;
  } kept_hash_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic                cfg_we    = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data  = '0;

  fms_byte_if byte_bus ();
  fms_hash_if hash_bus ();

  fracminhash_kmer_sampler_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .byte_i      (byte_bus),
    .hash_o      (hash_bus)
  );

  always #2 clk_i = ~clk_i;

  text_word_t  text_q[$];
  kept_hash_t  kept_hash_q[$];
  text_word_t  next_word;
  int unsigned queued_words   = 0;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count    = 0;
  int unsigned holdoff_left   = 0;
  logic        holdoff_used   = 1'b0;
  logic        stall_phase    = 1'b0;
  logic        calm           = 1'b0;

  // Predictor copy of the registers
  logic [4:0]  cur_k;
  logic        cur_fastq;
  logic        cur_mask_sel;
  logic [31:0] cur_smask;
  logic [63:0] cur_thresh;
  logic [4:0]  cur_sbits;

  // Predictor copy of the parser and window
  logic [WinW-1:0] win_fwd;
  logic [WinW-1:0] win_rev;
  int unsigned     win_fill;
  logic [1:0]      line_ph;
  logic            in_seq;

  function automatic logic [63:0] splitmix64(logic [63:0] x);
    logic [63:0] z;
    z = x + GoldenAdd;
    z = (z ^ (z >> 30)) * MixMulA;
    z = (z ^ (z >> 27)) * MixMulB;
    return z ^ (z >> 31);
  endfunction

  function automatic void drop_window();
    win_fwd  = '0;
    win_rev  = '0;
    win_fill = 0;
  endfunction

  function automatic void reset_predictor();
    cur_k        = 5'd21;
    cur_fastq    = 1'b1;
    cur_mask_sel = 1'b1;
    cur_smask    = 32'd1023;
    cur_thresh   = 64'd0;
    cur_sbits    = 5'd8;
    drop_window();
    line_ph = LineHeader;
    in_seq  = 1'b0;
  endfunction

  function automatic void note_reg(logic [CfgIdxW-1:0] idx, logic [63:0] val);
    case (idx)
      CFG_KMER_LENGTH:    cur_k        = val[4:0];
      CFG_FASTQ_MODE:     cur_fastq    = val[0];
      CFG_MASK_SEL:       cur_mask_sel = val[0];
      CFG_SAMPLE_MASK:    cur_smask    = val[31:0];
      CFG_KEEP_THRESHOLD: cur_thresh   = val;
      CFG_SHARD_WIDTH:    cur_sbits    = val[4:0];
      default: ;
    endcase
  endfunction

  // Roll one base into both windows, or clear them on a non-base; queue the hash if it is sampled
  function automatic void shift_base(logic [7:0] ch);
    logic [1:0]  code;
    logic        is_base;
    int unsigned k;
    int unsigned sb;
    logic [63:0] wmask;
    logic [63:0] fwd;
    logic [63:0] rev;
    logic [63:0] canon;
    logic [63:0] h;
    logic        keep;
    kept_hash_t  res;
    is_base = 1'b1;
    code    = BaseA;
    case (ch)
      "A", "a": code = BaseA;
      "C", "c": code = BaseC;
      "G", "g": code = BaseG;
      "T", "t": code = BaseT;
      default:  is_base = 1'b0;
    endcase
    if (!is_base) begin
      drop_window();
      return;
    end
    k = (cur_k == 0) ? 1 : ((cur_k > MaxK) ? MaxK : cur_k);
    wmask = (64'd1 << (2 * k)) - 64'd1;
    fwd = (({2'b00, win_fwd} << 2) | 64'(code)) & wmask;
    rev = (({2'b00, win_rev} >> 2) | (64'(code ^ ComplMask) << (2 * (k - 1)))) & wmask;
    win_fwd  = fwd[WinW-1:0];
    win_rev  = rev[WinW-1:0];
    win_fill = (win_fill < k) ? win_fill + 1 : k;
    if (win_fill != k) return;
    canon = (fwd < rev) ? fwd : rev;
    h = splitmix64(canon);
    keep = cur_mask_sel ? ((h & {32'd0, cur_smask}) == 64'd0) : (h < cur_thresh);
    if (!keep) return;
    sb = (cur_sbits == 0) ? 8 : ((cur_sbits > MaxShardBits) ? MaxShardBits : cur_sbits);
    res.hash  = h;
    res.shard = 16'(h >> (64 - sb));
    kept_hash_q.push_back(res);
  endfunction

  // Record parser: follows FASTQ line phase or FASTA header/sequence state
  function automatic void parse_text_word(logic [7:0] ch, logic chunk);
    if (chunk) begin
      drop_window();
      line_ph = LineHeader;
      in_seq  = 1'b0;
    end
    if (cur_fastq) begin
      if (ch == ChNl) begin
        if (line_ph == LineHeader) begin
          in_seq = 1'b1;
          drop_window();
        end else begin
          in_seq = 1'b0;
        end
        line_ph = line_ph + 2'd1;
      end else if (line_ph == LineSeq && ch != ChCr) begin
        shift_base(ch);
      end
    end else if (ch == ChGt) begin
      in_seq = 1'b0;
      drop_window();
    end else if (ch == ChNl) begin
      in_seq = 1'b1;
    end else if (in_seq && ch != ChCr) begin
      shift_base(ch);
    end
  endfunction

  function automatic void check_kept(logic [63:0] hash, logic [15:0] shard);
    kept_hash_t want;
    if (kept_hash_q.size() == 0) begin
      $display("%0t: kept hash expected none got %h shard %h", $time, hash, shard);
      mismatch_count++;
      return;
    end
    want = kept_hash_q.pop_front();
    if (hash !== want.hash) begin
      $display("%0t: kept_hash expected %h got %h", $time, want.hash, hash);
      mismatch_count++;
    end
    if (shard !== want.shard) begin
      $display("%0t: shard_index expected %h got %h", $time, want.shard, shard);
      mismatch_count++;
    end
  endfunction

  // ---- stimulus builders ----
  function automatic void push_word(logic [7:0] ch, logic chunk);
    text_word_t w;
    w.ch    = ch;
    w.chunk = chunk;
    text_q.push_back(w);
    queued_words++;
  endfunction

  function automatic logic [7:0] printable();
    return 8'($urandom_range(8'h7E, 8'h21));
  endfunction

  // Mostly clean bases in both cases, now and then an N, a CR or a stray byte
  function automatic logic [7:0] pick_base();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 3) return "N";
    if (r < 5) return ChCr;
    if (r < 7) return 8'($urandom_range(255));
    case ($urandom_range(7))
      0: return "A";
      1: return "C";
      2: return "G";
      3: return "T";
      4: return "a";
      5: return "c";
      6: return "g";
      default: return "t";
    endcase
  endfunction

  function automatic void push_fastq_record(int unsigned len, logic chunk);
    push_word(ChAt, chunk);
    repeat ($urandom_range(6, 1)) push_word(printable(), 1'b0);
    push_word(ChNl, 1'b0);
    repeat (len) push_word(pick_base(), 1'b0);
    if ($urandom_range(4) == 0) push_word(ChCr, 1'b0);
    push_word(ChNl, 1'b0);
    push_word(ChPlus, 1'b0);
    push_word(ChNl, 1'b0);
    repeat (len) push_word(printable(), 1'b0);
    push_word(ChNl, 1'b0);
  endfunction

  function automatic void push_fasta_record(int unsigned len, logic chunk);
    int unsigned left;
    int unsigned line;
    push_word(ChGt, chunk);
    repeat ($urandom_range(6, 1)) push_word(printable(), 1'b0);
    push_word(ChNl, 1'b0);
    left = len;
    while (left > 0) begin
      line = $urandom_range(30, 5);
      if (line > left) line = left;
      repeat (line) push_word(pick_base(), 1'b0);
      if ($urandom_range(4) == 0) push_word(ChCr, 1'b0);
      push_word(ChNl, 1'b0);
      left -= line;
    end
  endfunction

  // Well-formed records of the current format, with some of the other
  // format and bursts of random bytes; resync with chunk_start after those
  function automatic void fill_phase(int unsigned words, logic fastq);
    int unsigned stop;
    int unsigned len;
    logic        resync;
    stop   = queued_words + words;
    resync = 1'b1;
    while (queued_words < stop) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(62, 32) : $urandom_range(40, 4);
      case ($urandom_range(19))
        0: begin
          if (fastq) push_fasta_record(len, 1'b0);
          else push_fastq_record(len, 1'b0);
          resync = 1'b1;
        end
        1, 2: begin
          repeat ($urandom_range(6, 1))
            push_word(8'($urandom_range(255)), $urandom_range(3) == 0);
          resync = 1'b1;
        end
        default: begin
          if (fastq) push_fastq_record(len, resync || $urandom_range(9) == 0);
          else push_fasta_record(len, resync || $urandom_range(9) == 0);
          resync = 1'b0;
        end
      endcase
    end
  endfunction

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [63:0] val);
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    note_reg(idx, val);
  endtask

  task automatic end_writes();
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  // Wait for every word sent and every kept hash seen, then let the engine empty
  task automatic settle();
    while (text_q.size() != 0 || byte_bus.valid || kept_hash_q.size() != 0)
      @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // ---- driver: feeds text words, predicts on each accepted word ----
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      byte_bus.valid <= 1'b0;
    end else if (!byte_bus.valid || byte_bus.ready) begin
      if (byte_bus.valid) parse_text_word(byte_bus.text_byte, byte_bus.chunk_start);
      if (text_q.size() > 0 && (calm || $urandom_range(99) >= IdlePct)) begin
        next_word = text_q.pop_front();
        byte_bus.valid       <= 1'b1;
        byte_bus.text_byte   <= next_word.ch;
        byte_bus.chunk_start <= next_word.chunk;
      end else begin
        byte_bus.valid <= 1'b0;
      end
    end
  end

  // ---- monitor: random ready, one long hold-off, checks kept hashes ----
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      hash_bus.ready <= 1'b0;
    end else begin
      if (hash_bus.valid && hash_bus.ready)
        check_kept(hash_bus.kept_hash, hash_bus.shard_index);
      if (holdoff_left > 0) begin
        holdoff_left   <= holdoff_left - 1;
        hash_bus.ready <= 1'b0;
      end else if (stall_phase && !holdoff_used && hash_bus.valid) begin
        holdoff_left   <= HoldoffCycles;
        holdoff_used   <= 1'b1;
        hash_bus.ready <= 1'b0;
      end else begin
        hash_bus.ready <= calm || $urandom_range(99) >= IdlePct;
      end
    end
  end

  // ---- watchdog ----
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    byte_bus.valid       = 1'b0;
    byte_bus.text_byte   = '0;
    byte_bus.chunk_start = 1'b0;
    hash_bus.ready       = 1'b0;
    reset_predictor();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: short k, keep every k-mer, FASTQ from reset
    write_reg(CFG_KMER_LENGTH, 64'd3);
    write_reg(CFG_SAMPLE_MASK, 64'd0);
    end_writes();
    push_word(ChAt, 1'b1);
    push_word(ChNl, 1'b0);    // header ends: window cleared, sequence line
    push_word("A", 1'b0);
    push_word("c", 1'b0);
    push_word("G", 1'b0);     // first full window
    push_word(ChCr, 1'b0);    // skipped
    push_word("t", 1'b0);
    push_word("N", 1'b0);     // invalid base clears the window
    push_word("T", 1'b0);
    push_word("T", 1'b0);
    push_word("T", 1'b0);
    push_word(8'hFF, 1'b0);
    push_word(ChNl, 1'b0);
    push_word(ChPlus, 1'b0);
    push_word(ChNl, 1'b0);
    push_word(8'h00, 1'b0);   // quality line is ignored
    push_word(ChNl, 1'b0);
    push_word(ChAt, 1'b0);
    push_word(ChNl, 1'b0);
    push_word("A", 1'b0);
    push_word("C", 1'b0);
    push_word("G", 1'b1);     // chunk start mid-sequence drops back to header
    push_word("G", 1'b0);
    settle();

    for (int p = 0; p < 8; p++) begin
      case (p)
        0: begin
          // FASTA, widest window, keep nearly all, widest shard
          write_reg(CFG_KMER_LENGTH, 64'd31);
          write_reg(CFG_FASTQ_MODE, 64'd0);
          write_reg(CFG_MASK_SEL, 64'd0);
          write_reg(CFG_KEEP_THRESHOLD, 64'hFFFF_FFFF_FFFF_FFFF);
          write_reg(CFG_SHARD_WIDTH, 64'd16);
        end
        1: begin
          // junk in the upper data bits, spare indexes, narrowest shard
          write_reg(CFG_KMER_LENGTH, 64'hFFFF_FFFF_FFFF_FFE5);
          write_reg(CFG_FASTQ_MODE, 64'hFFFF_FFFF_FFFF_FFFF);
          write_reg(CFG_MASK_SEL, 64'd1);
          write_reg(CFG_SAMPLE_MASK, 64'hFFFF_FFFF_0000_0003);
          write_reg(CFG_SHARD_WIDTH, 64'd1);
          write_reg(CfgIdxSpareLo, 64'd0);
          write_reg(CfgIdxSpareHi, 64'hFFFF_FFFF_FFFF_FFFF);
        end
        2: begin
          // zero length reads as one base; zero shard bits read as eight
          write_reg(CFG_KMER_LENGTH, 64'd0);
          write_reg(CFG_FASTQ_MODE, 64'd0);
          write_reg(CFG_SAMPLE_MASK, 64'd0);
          write_reg(CFG_SHARD_WIDTH, 64'd0);
        end
        3: begin
          // threshold zero keeps nothing; shard bits above the cap
          write_reg(CFG_KMER_LENGTH, 64'd12);
          write_reg(CFG_FASTQ_MODE, 64'd1);
          write_reg(CFG_MASK_SEL, 64'd0);
          write_reg(CFG_KEEP_THRESHOLD, 64'd0);
          write_reg(CFG_SHARD_WIDTH, 64'd31);
        end
        4: begin
          write_reg(CFG_KMER_LENGTH, 64'd17);
          write_reg(CFG_FASTQ_MODE, 64'd0);
          write_reg(CFG_MASK_SEL, 64'd1);
          write_reg(CFG_SAMPLE_MASK, 64'hFFFF_FFFF);
        end
        default: begin
          write_reg(CFG_KMER_LENGTH, 64'($urandom_range(31)));
          write_reg(CFG_FASTQ_MODE, 64'($urandom_range(1)));
          write_reg(CFG_MASK_SEL, 64'($urandom_range(1)));
          write_reg(CFG_SAMPLE_MASK, 64'((32'd1 << $urandom_range(4)) - 32'd1));
          write_reg(CFG_KEEP_THRESHOLD, {$urandom, $urandom});
          write_reg(CFG_SHARD_WIDTH, 64'($urandom_range(31)));
        end
      endcase
      end_writes();
      // every base is kept in the one-base phase, so the hold-off fills the block
      stall_phase = (p == 2);
      calm        = (p == 2);
      fill_phase((p == 0) ? 200 : ((p == 1) ? 150 : ((p < 5) ? 100 : 200)), cur_fastq);
      settle();
    end

    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/fms_pkg.sv
rtl/fms_if.sv
rtl/fms_front.sv
rtl/fms_queue.sv
rtl/fms_back.sv
rtl/fracminhash_kmer_sampler_top.sv
bench/fracminhash_kmer_sampler_top_tb.sv
